>>> hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define DRT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("drt assertion failed");

// condition must never be true outside reset
`define DRT_NEVER(lbl, clk, rstn, cond) \
  `DRT_ASSERT(lbl, clk, rstn, !(cond))

`else

`define DRT_ASSERT(lbl, clk, rstn, prop)
`define DRT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> hdl/drt_pkg.sv
// shared types, codes and box helpers of the dirty rectangle tracker
`timescale 1ns / 1ps

package drt_pkg;

  localparam int MAX_RECTS_DEFAULT = 16;
  localparam int CoordW = 15;
  localparam int InW = 16;
  localparam int CountOutW = 7;
  localparam int IndexInW = 6;

  // item modes
  localparam logic [1:0] MODE_MARK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
  } box_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic rd_idx;
    logic scan_rd;
    logic scan_next;
    logic scan_hit;
    logic c_rd;
    logic c_next;
    logic c_absorb;
    logic rd_last;
    logic move_wr;
    logic wb;
    logic place;
    logic set_dirty;
    logic latch_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;
    logic read_ok;
    logic cnt_zero;
    logic i_last;
    logic scan_touch;
    logic casc_touch;
    logic j_end;
    logic j_is_tgt;
    logic need_move;
  } sts_t;

  // overlap or shared edge on both axes
  function automatic logic box_touch(box_t a, box_t b);
    logic [CoordW:0] ar;
    logic [CoordW:0] br;
    logic [CoordW:0] ab;
    logic [CoordW:0] bb;
    ar = {1'b0, a.x} + {1'b0, a.w};
    br = {1'b0, b.x} + {1'b0, b.w};
    ab = {1'b0, a.y} + {1'b0, a.h};
    bb = {1'b0, b.y} + {1'b0, b.h};
    return ({1'b0, a.x} <= br) && ({1'b0, b.x} <= ar) &&
           ({1'b0, a.y} <= bb) && ({1'b0, b.y} <= ab);
  endfunction

  // bounding box of two boxes, extents wrap to coordinate width
  function automatic box_t box_grow(box_t t, box_t s);
    box_t res;
    logic [CoordW:0] tr;
    logic [CoordW:0] sr;
    logic [CoordW:0] tb;
    logic [CoordW:0] sb;
    logic [CoordW:0] rr;
    logic [CoordW:0] rb;
    logic [CoordW:0] dw;
    logic [CoordW:0] dh;
    tr = {1'b0, t.x} + {1'b0, t.w};
    sr = {1'b0, s.x} + {1'b0, s.w};
    tb = {1'b0, t.y} + {1'b0, t.h};
    sb = {1'b0, s.y} + {1'b0, s.h};
    rr = (tr > sr) ? tr : sr;
    rb = (tb > sb) ? tb : sb;
    res.x = (t.x < s.x) ? t.x : s.x;
    res.y = (t.y < s.y) ? t.y : s.y;
    dw = rr - {1'b0, res.x};
    dh = rb - {1'b0, res.y};
    res.w = dw[CoordW-1:0];
    res.h = dh[CoordW-1:0];
    return res;
  endfunction

endpackage

>>> hdl/drt_ctrl.sv
// sequencing state machine of the dirty rectangle tracker
`timescale 1ns / 1ps

module drt_ctrl import drt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] mode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy,
  output logic       done_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SCAN_RD  = 10'b0000000010,
    S_SCAN_CHK = 10'b0000000100,
    S_PLACE    = 10'b0000001000,
    S_C_RD     = 10'b0000010000,
    S_C_CHK    = 10'b0000100000,
    S_C_MOVE   = 10'b0001000000,
    S_C_WB     = 10'b0010000000,
    S_R_WAIT   = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (mode_i)
            MODE_MARK: begin
              if (sts_i.drop) begin
                state_d = S_DONE;
              end else if (sts_i.cnt_zero) begin
                state_d = S_PLACE;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            MODE_READ: begin
              if (sts_i.read_ok) begin
                cmd_o.rd_idx = 1'b1;
                state_d = S_R_WAIT;
              end else begin
                state_d = S_DONE;
              end
            end
            MODE_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.scan_touch) begin
          cmd_o.scan_hit = 1'b1;
          state_d = S_C_RD;
        end else if (sts_i.i_last) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_PLACE: begin
        cmd_o.place     = 1'b1;
        cmd_o.set_dirty = 1'b1;
        state_d = S_DONE;
      end
      S_C_RD: begin
        if (sts_i.j_end) begin
          state_d = S_C_WB;
        end else if (sts_i.j_is_tgt) begin
          cmd_o.c_next = 1'b1;
        end else begin
          cmd_o.c_rd = 1'b1;
          state_d = S_C_CHK;
        end
      end
      S_C_CHK: begin
        if (sts_i.casc_touch) begin
          cmd_o.c_absorb = 1'b1;
          if (sts_i.need_move) begin
            // fetch the last entry to refill the absorbed slot
            cmd_o.rd_last = 1'b1;
            state_d = S_C_MOVE;
          end else begin
            state_d = S_C_RD;
          end
        end else begin
          cmd_o.c_next = 1'b1;
          state_d = S_C_RD;
        end
      end
      S_C_MOVE: begin
        cmd_o.move_wr = 1'b1;
        state_d = S_C_RD;
      end
      S_C_WB: begin
        cmd_o.wb        = 1'b1;
        cmd_o.set_dirty = 1'b1;
        state_d = S_DONE;
      end
      S_R_WAIT: begin
        cmd_o.latch_out = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

>>> hdl/drt_dp.sv
// entry memory, working boxes, counters and frame size of the tracker
`timescale 1ns / 1ps

module drt_dp import drt_pkg::*; #(
  parameter int MAX_RECTS = MAX_RECTS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CoordW-1:0]    cfg_data_i,
  input  logic [InW-1:0]       rect_x_i,
  input  logic [InW-1:0]       rect_y_i,
  input  logic [InW-1:0]       rect_w_i,
  input  logic [InW-1:0]       rect_h_i,
  input  logic [IndexInW-1:0]  entry_index_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 any_dirty_o,
  output logic [CountOutW-1:0] entry_count_o,
  output logic                 entry_valid_o,
  output logic [CoordW-1:0]    out_x_o,
  output logic [CoordW-1:0]    out_y_o,
  output logic [CoordW-1:0]    out_w_o,
  output logic [CoordW-1:0]    out_h_o
);

  localparam int IdxW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CntW = $clog2(MAX_RECTS + 1);

  box_t mem_q [MAX_RECTS];
  box_t rdata_q;

  logic [CoordW-1:0] fw_q, fh_q;
  logic [CntW-1:0]   cnt_q, i_q, j_q;
  logic [IdxW-1:0]   tgt_q;
  logic              dirty_q, valid_q;
  box_t              r_q, t_q, out_q;

  logic [CntW-1:0] last;
  logic            full;
  logic            tgt_last;
  box_t            clip_box;
  box_t            grow_scan, grow_casc;
  logic [InW:0]    mx, my, mxc, myc, wc, hc;
  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  box_t            wr_data;

  assign last     = cnt_q - 1'b1;
  assign full     = (cnt_q >= CntW'(MAX_RECTS));
  assign tgt_last = (CntW'(tgt_q) == last);

  // clip the incoming box to the frame
  always_comb begin
    mx  = {1'b0, rect_x_i} + {1'b0, rect_w_i};
    my  = {1'b0, rect_y_i} + {1'b0, rect_h_i};
    mxc = (mx > (InW+1)'(fw_q)) ? (InW+1)'(fw_q) : mx;
    myc = (my > (InW+1)'(fh_q)) ? (InW+1)'(fh_q) : my;
    wc  = mxc - {1'b0, rect_x_i};
    hc  = myc - {1'b0, rect_y_i};
    clip_box.x = rect_x_i[CoordW-1:0];
    clip_box.y = rect_y_i[CoordW-1:0];
    clip_box.w = wc[CoordW-1:0];
    clip_box.h = hc[CoordW-1:0];
  end

  assign grow_scan = box_grow(rdata_q, r_q);
  assign grow_casc = box_grow(t_q, rdata_q);

  always_comb begin
    sts_o.drop = (fw_q == '0) || (fh_q == '0) || (rect_w_i == '0) || (rect_h_i == '0) ||
                 (rect_x_i >= {1'b0, fw_q}) || (rect_y_i >= {1'b0, fh_q});
    sts_o.read_ok    = ({1'b0, entry_index_i} < CountOutW'(cnt_q)) &&
                       ({1'b0, entry_index_i} < CountOutW'(MAX_RECTS));
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.i_last     = (({1'b0, i_q} + 1'b1) == {1'b0, cnt_q});
    sts_o.scan_touch = box_touch(rdata_q, r_q);
    sts_o.casc_touch = box_touch(t_q, rdata_q);
    sts_o.j_end      = (j_q >= cnt_q);
    sts_o.j_is_tgt   = (j_q == CntW'(tgt_q));
    sts_o.need_move  = !tgt_last && (j_q != last);
  end

  // single read port and single write port of the entry memory
  always_comb begin
    rd_en   = cmd_i.rd_idx | cmd_i.scan_rd | cmd_i.c_rd | cmd_i.rd_last;
    rd_addr = i_q[IdxW-1:0];
    if (cmd_i.rd_idx) begin
      rd_addr = entry_index_i[IdxW-1:0];
    end else if (cmd_i.c_rd) begin
      rd_addr = j_q[IdxW-1:0];
    end else if (cmd_i.rd_last) begin
      rd_addr = last[IdxW-1:0];
    end
    wr_en   = cmd_i.move_wr | cmd_i.wb | cmd_i.place;
    wr_addr = j_q[IdxW-1:0];
    wr_data = rdata_q;
    if (cmd_i.wb) begin
      wr_addr = tgt_q;
      wr_data = t_q;
    end else if (cmd_i.place) begin
      if (full) begin
        // table full: collapse to one full-frame entry
        wr_addr = '0;
        wr_data = '{x: '0, y: '0, w: fw_q, h: fh_q};
      end else begin
        wr_addr = cnt_q[IdxW-1:0];
        wr_data = r_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= '0;
      fh_q    <= '0;
      cnt_q   <= '0;
      dirty_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      tgt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
          CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        i_q     <= '0;
        valid_q <= 1'b0;
      end
      if (cmd_i.latch_out) begin
        valid_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        cnt_q   <= '0;
        dirty_q <= 1'b0;
      end
      if (cmd_i.set_dirty) begin
        dirty_q <= 1'b1;
      end
      if (cmd_i.scan_next) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.scan_hit) begin
        tgt_q <= i_q[IdxW-1:0];
        j_q   <= '0;
      end
      if (cmd_i.c_next) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.c_absorb) begin
        // grown entry was last: it moves into the absorbed slot
        if (tgt_last) begin
          tgt_q <= j_q[IdxW-1:0];
        end
        if (!sts_o.need_move) begin
          cnt_q <= cnt_q - 1'b1;
          j_q   <= '0;
        end
      end
      if (cmd_i.move_wr) begin
        cnt_q <= cnt_q - 1'b1;
        j_q   <= '0;
      end
      if (cmd_i.place) begin
        cnt_q <= full ? CntW'(1) : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q   <= clip_box;
      out_q <= '0;
    end
    if (cmd_i.latch_out) begin
      out_q <= rdata_q;
    end
    if (cmd_i.scan_hit) begin
      t_q <= grow_scan;
    end
    if (cmd_i.c_absorb) begin
      t_q <= grow_casc;
    end
  end

  assign any_dirty_o   = dirty_q;
  assign entry_count_o = CountOutW'(cnt_q);
  assign entry_valid_o = valid_q;
  assign out_x_o       = out_q.x;
  assign out_y_o       = out_q.y;
  assign out_w_o       = out_q.w;
  assign out_h_o       = out_q.h;

endmodule

>>> hdl/dirty_rectangle_tracker_top.sv
// top level of the dirty rectangle tracker: controller, datapath and checks
// clear, unused mode, dropped mark, out-of-range read: result in the cycle after accept
// read: S_R_WAIT, then S_DONE; the next item is taken in the cycle after any result
// mark: S_SCAN_RD, S_SCAN_CHK per entry scanned, S_PLACE to append; on a hit absorb passes
//   (S_C_RD, S_C_CHK per entry, S_C_RD skips grown entry, S_C_MOVE refills), then S_C_WB
// reset clears count, dirty flag, frame size and controller; entry memory is not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dirty_rectangle_tracker_top import drt_pkg::*; #(
  parameter int MAX_RECTS = MAX_RECTS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CoordW-1:0]    cfg_data_i,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode_i,
  input  logic [InW-1:0]       rect_x_i,
  input  logic [InW-1:0]       rect_y_i,
  input  logic [InW-1:0]       rect_w_i,
  input  logic [InW-1:0]       rect_h_i,
  input  logic [IndexInW-1:0]  entry_index_i,
  output logic                 done_o,
  output logic                 any_dirty_o,
  output logic [CountOutW-1:0] entry_count_o,
  output logic                 entry_valid_o,
  output logic [CoordW-1:0]    out_x_o,
  output logic [CoordW-1:0]    out_y_o,
  output logic [CoordW-1:0]    out_w_o,
  output logic [CoordW-1:0]    out_h_o
);

  cmd_t cmd;
  sts_t sts;

  drt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  drt_dp #(
    .MAX_RECTS (MAX_RECTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .rect_x_i      (rect_x_i),
    .rect_y_i      (rect_y_i),
    .rect_w_i      (rect_w_i),
    .rect_h_i      (rect_h_i),
    .entry_index_i (entry_index_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .any_dirty_o   (any_dirty_o),
    .entry_count_o (entry_count_o),
    .entry_valid_o (entry_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_w_o       (out_w_o),
    .out_h_o       (out_h_o)
  );

  // an accepted item always occupies the block, and a result frees it
  `DRT_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy)
  `DRT_ASSERT(a_done_frees, clk_i, rst_ni, done_o |=> !busy)
  `DRT_NEVER(a_done_idle, clk_i, rst_ni, done_o && !busy)
  `DRT_NEVER(a_count_range, clk_i, rst_ni, entry_count_o > CountOutW'(MAX_RECTS))
  `DRT_NEVER(a_valid_needs_entry, clk_i, rst_ni,
             done_o && entry_valid_o && (entry_count_o == '0))

endmodule
